[hw/rtl/owt_pkg.sv]
`default_nettype none

package owt_pkg;

   // Input word modes.
   localparam logic [1:0] MODE_TICK  = 2'd0;
   localparam logic [1:0] MODE_TOUCH = 2'd1;
   localparam logic [1:0] MODE_LIGHT = 2'd2;

   // Touch event codes.
   localparam logic [1:0] EV_NONE     = 2'd0;
   localparam logic [1:0] EV_DOWN     = 2'd1;
   localparam logic [1:0] EV_RELEASED = 2'd2;

   // Configuration register indexes.
   localparam logic CSR_HOLD_TICKS   = 1'b0;
   localparam logic CSR_MAX_ATTEMPTS = 1'b1;

   localparam logic [7:0]  HOLD_TICKS_RESET   = 8'd60;
   localparam logic [2:0]  MAX_ATTEMPTS_RESET = 3'd3;
   localparam logic [7:0]  CRC_INIT           = 8'hAC;
   localparam logic [7:0]  CRC_POLY           = 8'h07;
   localparam logic [7:0]  TOUCH_REQUEST      = 8'h40;
   localparam logic [6:0]  BRIGHT_MAX         = 7'd127;
   localparam logic [11:0] NO_TOUCH_POS       = 12'hFFF;
   localparam logic [7:0]  LOW_TICKS          = 8'd2;
   localparam logic [5:0]  SEND_BITS          = 6'd16;
   localparam logic [5:0]  CRC_BITS           = 6'd24;
   localparam logic [5:0]  RECV_BITS          = 6'd32;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_HOLD,
      PH_LOW,
      PH_SEND,
      PH_TAIL,
      PH_WAIT,
      PH_RECV
   } phase_type;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] brightness;
      logic       line_sample;
   } req_item_type;

   typedef struct packed {
      logic        line_drive_enable;
      logic        line_level;
      logic        busy_res;
      logic        done_res;
      logic        ok;
      logic [31:0] response_word;
      logic [11:0] x_pos;
      logic [11:0] y_pos;
      logic        touching;
      logic [1:0]  touch_event;
   } rsp_item_type;

   // One CRC-8 step, data entered MSB first.
   function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic data_bit);
      logic [7:0] shifted;
      shifted = {crc[6:0], 1'b0};
      if (crc[7] ^ data_bit) begin
         shifted = shifted ^ CRC_POLY;
      end
      return shifted;
   endfunction

   // CRC-8 of one byte: eight steps on an 8-bit value.
   function automatic logic [7:0] crc_byte(input logic [7:0] data);
      logic [7:0] crc;
      crc = CRC_INIT;
      for (int i = 7; i >= 0; i--) begin
         crc = crc_step(crc, data[i]);
      end
      return crc;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/owt_engine.sv]
`default_nettype none

module owt_engine
   import owt_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         advance,
   input  wire req_item_type item,
   input  wire logic [7:0]   hold_ticks,
   input  wire logic [2:0]   max_attempts,
   output rsp_item_type      result
);

   phase_type   phase_ff, phase_in;
   logic [7:0]  tick_count_ff, tick_count_in;
   logic [5:0]  bit_count_ff, bit_count_in;
   logic [15:0] send_shift_ff, send_shift_in;
   logic [31:0] receive_shift_ff, receive_shift_in;
   logic [2:0]  attempt_count_ff, attempt_count_in;
   logic [7:0]  request_byte_ff, request_byte_in;
   logic        query_is_touch_ff, query_is_touch_in;
   logic        release_pending_ff, release_pending_in;
   logic [11:0] last_down_x_ff, last_down_x_in;
   logic [11:0] last_down_y_ff, last_down_y_in;
   logic [7:0]  recv_crc_ff, recv_crc_in;

   logic [7:0]  tick_next;
   logic [5:0]  bit_next;
   logic [2:0]  attempt_next;
   logic [31:0] shift_next;
   logic [11:0] x_dec, y_dec;
   logic [7:0]  start_byte;
   logic [6:0]  bright_clamped;
   logic        retry;

   always_comb begin
      phase_in           = phase_ff;
      tick_count_in      = tick_count_ff;
      bit_count_in       = bit_count_ff;
      send_shift_in      = send_shift_ff;
      receive_shift_in   = receive_shift_ff;
      attempt_count_in   = attempt_count_ff;
      request_byte_in    = request_byte_ff;
      query_is_touch_in  = query_is_touch_ff;
      release_pending_in = release_pending_ff;
      last_down_x_in     = last_down_x_ff;
      last_down_y_in     = last_down_y_ff;
      recv_crc_in        = recv_crc_ff;

      result             = '0;
      retry              = 1'b0;
      start_byte         = request_byte_ff;

      tick_next    = tick_count_ff + 8'd1;
      bit_next     = bit_count_ff + 6'd1;
      attempt_next = attempt_count_ff + 3'd1;
      shift_next   = {receive_shift_ff[30:0], item.line_sample};
      x_dec        = {shift_next[31:28], shift_next[23:16]};
      y_dec        = {shift_next[27:24], shift_next[15:8]};
      bright_clamped = (item.brightness > {1'b0, BRIGHT_MAX}) ? BRIGHT_MAX
                                                             : item.brightness[6:0];

      if (phase_ff == PH_IDLE && (item.mode == MODE_TOUCH || item.mode == MODE_LIGHT)) begin
         if (item.mode == MODE_TOUCH) begin
            start_byte        = TOUCH_REQUEST;
            query_is_touch_in = 1'b1;
         end else begin
            start_byte        = {1'b1, bright_clamped};
            query_is_touch_in = 1'b0;
         end
         request_byte_in  = start_byte;
         attempt_count_in = 3'd0;
         retry            = 1'b1;
      end else if (item.mode == MODE_TICK && phase_ff != PH_IDLE) begin
         case (phase_ff)
            PH_HOLD: begin
               if (tick_next >= hold_ticks) begin
                  phase_in      = PH_LOW;
                  tick_count_in = 8'd0;
               end else begin
                  tick_count_in = tick_next;
               end
            end
            PH_LOW: begin
               if (tick_next >= LOW_TICKS) begin
                  phase_in      = PH_SEND;
                  tick_count_in = 8'd0;
                  bit_count_in  = 6'd0;
               end else begin
                  tick_count_in = tick_next;
               end
            end
            PH_SEND: begin
               bit_count_in = bit_next;
               if (bit_next >= SEND_BITS) begin
                  phase_in = PH_TAIL;
               end else begin
                  send_shift_in = {send_shift_ff[14:0], 1'b0};
               end
            end
            PH_TAIL: begin
               phase_in = PH_WAIT;
            end
            PH_WAIT: begin
               phase_in     = PH_RECV;
               bit_count_in = 6'd0;
               recv_crc_in  = CRC_INIT;
            end
            PH_RECV: begin
               receive_shift_in = shift_next;
               bit_count_in     = bit_next;
               // The check value is built as the bits arrive; only the first 24 count.
               if (bit_count_ff < CRC_BITS) begin
                  recv_crc_in = crc_step(recv_crc_ff, item.line_sample);
               end
               if (bit_next >= RECV_BITS) begin
                  if (recv_crc_ff == shift_next[7:0]) begin
                     result.done_res = 1'b1;
                     result.ok       = 1'b1;
                     phase_in        = PH_IDLE;
                     if (query_is_touch_ff) begin
                        result.x_pos = x_dec;
                        result.y_pos = y_dec;
                        if (x_dec != NO_TOUCH_POS && y_dec != NO_TOUCH_POS) begin
                           result.touching    = 1'b1;
                           result.touch_event = EV_DOWN;
                           last_down_x_in     = x_dec;
                           last_down_y_in     = y_dec;
                           release_pending_in = 1'b1;
                        end else if (release_pending_ff) begin
                           result.touch_event = EV_RELEASED;
                           result.x_pos       = last_down_x_ff;
                           result.y_pos       = last_down_y_ff;
                           release_pending_in = 1'b0;
                        end
                     end
                  end else begin
                     attempt_count_in = attempt_next;
                     if (attempt_next >= max_attempts) begin
                        result.done_res = 1'b1;
                        phase_in        = PH_IDLE;
                     end else begin
                        retry = 1'b1;
                     end
                  end
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end

      if (retry) begin
         phase_in         = PH_HOLD;
         tick_count_in    = 8'd0;
         bit_count_in     = 6'd0;
         receive_shift_in = 32'd0;
         send_shift_in    = {start_byte, crc_byte(start_byte)};
      end

      case (phase_in)
         PH_LOW: begin
            result.line_drive_enable = 1'b1;
            result.line_level        = 1'b0;
         end
         PH_SEND, PH_TAIL: begin
            result.line_drive_enable = 1'b1;
            result.line_level        = send_shift_in[15];
         end
         PH_WAIT, PH_RECV: begin
            result.line_drive_enable = 1'b0;
            result.line_level        = 1'b0;
         end
         default: begin
            result.line_drive_enable = 1'b1;
            result.line_level        = 1'b1;
         end
      endcase
      result.busy_res      = (phase_in != PH_IDLE);
      result.response_word = receive_shift_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= PH_IDLE;
         tick_count_ff      <= '0;
         bit_count_ff       <= '0;
         send_shift_ff      <= '0;
         receive_shift_ff   <= '0;
         attempt_count_ff   <= '0;
         request_byte_ff    <= '0;
         query_is_touch_ff  <= 1'b0;
         release_pending_ff <= 1'b0;
         last_down_x_ff     <= '0;
         last_down_y_ff     <= '0;
         recv_crc_ff        <= CRC_INIT;
      end else if (advance) begin
         phase_ff           <= phase_in;
         tick_count_ff      <= tick_count_in;
         bit_count_ff       <= bit_count_in;
         send_shift_ff      <= send_shift_in;
         receive_shift_ff   <= receive_shift_in;
         attempt_count_ff   <= attempt_count_in;
         request_byte_ff    <= request_byte_in;
         query_is_touch_ff  <= query_is_touch_in;
         release_pending_ff <= release_pending_in;
         last_down_x_ff     <= last_down_x_in;
         last_down_y_ff     <= last_down_y_in;
         recv_crc_ff        <= recv_crc_in;
      end
   end

   a_ok_ends_session: assert property (@(posedge clock) disable iff (reset)
      result.ok |-> (result.done_res && !result.busy_res))
      else $error("good reply did not end the session");

   a_down_is_touching: assert property (@(posedge clock) disable iff (reset)
      (result.touch_event == EV_DOWN) |-> (result.touching && query_is_touch_ff))
      else $error("down event without a touching reply");

   a_recv_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_RECV) |-> (bit_count_ff < RECV_BITS))
      else $error("receive bit count ran past the reply length");

   a_attempt_limit: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_IDLE && max_attempts != 3'd0) |-> (attempt_count_ff < max_attempts))
      else $error("session kept running past the attempt limit");

   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE && advance && item.mode == MODE_TICK) |=> (phase_ff == PH_IDLE))
      else $error("tick left the idle phase");

endmodule

`default_nettype wire

[hw/rtl/one_wire_touch_link_session_core.sv]
`default_nettype none

// One-wire touch panel link engine. Every request word (a bit-time tick or a
// start command) yields exactly one response word showing the line drive, the
// session status and, at the end of a session, the received reply and any
// decoded touch event. A word is taken in every clock cycle unless req_stall
// is high; a response passes through the input register and then the result
// register before it is presented.
// A held response lets one more request into the input register, after which
// the input stalls until the response is taken. The reply check value is
// accumulated one bit per tick, so no step of the logic is wider than one CRC
// byte. Configuration writes are always ready and should only be made while no
// session is running.
module one_wire_touch_link_session_core
   import owt_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [1:0]  req_mode,
   input  wire logic [7:0]  req_brightness,
   input  wire logic        req_line_sample,

   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic        rsp_line_drive_enable,
   output      logic        rsp_line_level,
   output      logic        rsp_busy_res,
   output      logic        rsp_done_res,
   output      logic        rsp_ok,
   output      logic [31:0] rsp_response_word,
   output      logic [11:0] rsp_x_pos,
   output      logic [11:0] rsp_y_pos,
   output      logic        rsp_touching,
   output      logic [1:0]  rsp_touch_event,

   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic        csr_index,
   input  wire logic [7:0]  csr_wdata
);

   logic         req_valid_ff, req_valid_in;
   req_item_type req_ff, req_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_ff;
   rsp_item_type step_result;
   logic [7:0]   hold_ticks_ff;
   logic [2:0]   max_attempts_ff;
   logic         advance;
   logic         req_take;

   // The held word moves into the result register whenever that register is
   // free or being emptied in this cycle.
   assign advance   = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = req_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      req_in.mode        = req_mode;
      req_in.brightness  = req_brightness;
      req_in.line_sample = req_line_sample;
      req_valid_in       = req_stall ? req_valid_ff : req_valid;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   owt_engine u_engine (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .item         (req_ff),
      .hold_ticks   (hold_ticks_ff),
      .max_attempts (max_attempts_ff),
      .result       (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff    <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         hold_ticks_ff   <= HOLD_TICKS_RESET;
         max_attempts_ff <= MAX_ATTEMPTS_RESET;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_HOLD_TICKS:   hold_ticks_ff   <= csr_wdata;
               CSR_MAX_ATTEMPTS: max_attempts_ff <= csr_wdata[2:0];
               default:          hold_ticks_ff   <= hold_ticks_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff <= req_in;
      end
      if (advance) begin
         rsp_ff <= step_result;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_line_drive_enable = rsp_ff.line_drive_enable;
   assign rsp_line_level        = rsp_ff.line_level;
   assign rsp_busy_res          = rsp_ff.busy_res;
   assign rsp_done_res          = rsp_ff.done_res;
   assign rsp_ok                = rsp_ff.ok;
   assign rsp_response_word     = rsp_ff.response_word;
   assign rsp_x_pos             = rsp_ff.x_pos;
   assign rsp_y_pos             = rsp_ff.y_pos;
   assign rsp_touching          = rsp_ff.touching;
   assign rsp_touch_event       = rsp_ff.touch_event;

endmodule

`default_nettype wire

[tb/one_wire_touch_link_session_core_tb.sv]
module one_wire_touch_link_session_core_tb;
   import owt_pkg::*;

   // Mode code that the block treats as a no-op.
   localparam logic [1:0] MODE_NONE = 2'd3;

   // Word shown while idle (line driven high) and during the hold phase.
   localparam rsp_item_type IDLE_SHOWN = {2'b11, 62'd0};
   localparam rsp_item_type HOLD_SHOWN = {3'b111, 61'd0};

   typedef struct packed {
      phase_type   phase;
      logic [7:0]  ticks;
      logic [5:0]  bits;
      logic [15:0] tx_shift;
      logic [31:0] rx_shift;
      logic [2:0]  attempts;
      logic [7:0]  request;
      logic        is_touch;
      logic        release_pending;
      logic [11:0] down_x;
      logic [11:0] down_y;
   } link_state_type;

   typedef struct packed {
      req_item_type stim;
      logic         typed;
      rsp_item_type shown;
   } directed_row_type;

   localparam int DIRECTED_ROWS = 10;
   localparam directed_row_type DIRECTED [DIRECTED_ROWS] = '{
      {MODE_TICK,  8'h00, 1'b0, 1'b1, IDLE_SHOWN},
      {MODE_TICK,  8'hFF, 1'b1, 1'b1, IDLE_SHOWN},
      {MODE_NONE,  8'hFF, 1'b1, 1'b1, IDLE_SHOWN},
      {MODE_NONE,  8'h00, 1'b0, 1'b1, IDLE_SHOWN},
      {MODE_LIGHT, 8'hFF, 1'b0, 1'b1, HOLD_SHOWN},
      {MODE_TOUCH, 8'h00, 1'b1, 1'b1, HOLD_SHOWN},
      {MODE_LIGHT, 8'h80, 1'b0, 1'b1, HOLD_SHOWN},
      {MODE_NONE,  8'h7F, 1'b1, 1'b1, HOLD_SHOWN},
      {MODE_TICK,  8'h00, 1'b1, 1'b0, HOLD_SHOWN},
      {MODE_TICK,  8'hFF, 1'b0, 1'b0, HOLD_SHOWN}
   };

   localparam int SETTINGS_COUNT = 5;
   localparam int SETTING_WORDS [SETTINGS_COUNT] = '{180, 150, 260, 200, 240};
   localparam int SETTING_BAD_PCT [SETTINGS_COUNT] = '{25, 30, 30, 60, 35};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_mode = MODE_TICK;
   logic [7:0]  req_brightness = 8'd0;
   logic        req_line_sample = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_line_drive_enable;
   logic        rsp_line_level;
   logic        rsp_busy_res;
   logic        rsp_done_res;
   logic        rsp_ok;
   logic [31:0] rsp_response_word;
   logic [11:0] rsp_x_pos;
   logic [11:0] rsp_y_pos;
   logic        rsp_touching;
   logic [1:0]  rsp_touch_event;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = CSR_HOLD_TICKS;
   logic [7:0]  csr_wdata = 8'd0;

   link_state_type link;
   logic [7:0]     hold_cfg;
   logic [2:0]     attempts_cfg;
   logic [31:0]    reply_bits;
   rsp_item_type   link_reports_due [$];

   int sender_idle_pct = 0;
   int stall_pct = 0;
   int words_sent = 0;
   int errors = 0;
   int sessions_done = 0;
   int sessions_good = 0;
   int downs_seen = 0;
   int releases_seen = 0;

   one_wire_touch_link_session_core i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_mode              (req_mode),
      .req_brightness        (req_brightness),
      .req_line_sample       (req_line_sample),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_line_drive_enable (rsp_line_drive_enable),
      .rsp_line_level        (rsp_line_level),
      .rsp_busy_res          (rsp_busy_res),
      .rsp_done_res          (rsp_done_res),
      .rsp_ok                (rsp_ok),
      .rsp_response_word     (rsp_response_word),
      .rsp_x_pos             (rsp_x_pos),
      .rsp_y_pos             (rsp_y_pos),
      .rsp_touching          (rsp_touching),
      .rsp_touch_event       (rsp_touch_event),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // CRC-8 over the top nbits of data, entered MSB first.
   function automatic logic [7:0] link_crc(input logic [31:0] data, input int nbits);
      logic [7:0] crc;
      logic       feedback;
      int         i;
      crc = CRC_INIT;
      for (i = 0; i < nbits; i++) begin
         feedback = crc[7] ^ data[31];
         crc = {crc[6:0], 1'b0};
         if (feedback) begin
            crc = crc ^ CRC_POLY;
         end
         data = data << 1;
      end
      return crc;
   endfunction

   function automatic void begin_attempt();
      link.phase = PH_HOLD;
      link.ticks = '0;
      link.bits = '0;
      link.rx_shift = '0;
      link.tx_shift = {link.request, link_crc({link.request, 24'd0}, 8)};
   endfunction

   // Advances the session state by one request word and returns the word it shows.
   function automatic rsp_item_type step_link_session(input req_item_type w);
      rsp_item_type r;
      logic [11:0]  x;
      logic [11:0]  y;
      r = '0;
      if (link.phase == PH_IDLE && (w.mode == MODE_TOUCH || w.mode == MODE_LIGHT)) begin
         if (w.mode == MODE_TOUCH) begin
            link.request = TOUCH_REQUEST;
            link.is_touch = 1'b1;
         end else begin
            link.request = {1'b1, (w.brightness > BRIGHT_MAX) ? BRIGHT_MAX : w.brightness[6:0]};
            link.is_touch = 1'b0;
         end
         link.attempts = '0;
         begin_attempt();
      end else if (w.mode == MODE_TICK && link.phase != PH_IDLE) begin
         case (link.phase)
            PH_HOLD: begin
               link.ticks = link.ticks + 8'd1;
               if (link.ticks >= hold_cfg) begin
                  link.phase = PH_LOW;
                  link.ticks = '0;
               end
            end
            PH_LOW: begin
               link.ticks = link.ticks + 8'd1;
               if (link.ticks >= LOW_TICKS) begin
                  link.phase = PH_SEND;
                  link.ticks = '0;
                  link.bits = '0;
               end
            end
            PH_SEND: begin
               link.bits = link.bits + 6'd1;
               if (link.bits >= SEND_BITS) begin
                  link.phase = PH_TAIL;
               end else begin
                  link.tx_shift = link.tx_shift << 1;
               end
            end
            PH_TAIL: begin
               link.phase = PH_WAIT;
            end
            PH_WAIT: begin
               link.phase = PH_RECV;
               link.bits = '0;
            end
            default: begin
               link.rx_shift = {link.rx_shift[30:0], w.line_sample};
               link.bits = link.bits + 6'd1;
               if (link.bits >= RECV_BITS) begin
                  if (link_crc(link.rx_shift, 24) == link.rx_shift[7:0]) begin
                     r.done_res = 1'b1;
                     r.ok = 1'b1;
                     link.phase = PH_IDLE;
                     if (link.is_touch) begin
                        x = {link.rx_shift[31:28], link.rx_shift[23:16]};
                        y = {link.rx_shift[27:24], link.rx_shift[15:8]};
                        r.x_pos = x;
                        r.y_pos = y;
                        if (x != NO_TOUCH_POS && y != NO_TOUCH_POS) begin
                           r.touching = 1'b1;
                           r.touch_event = EV_DOWN;
                           link.down_x = x;
                           link.down_y = y;
                           link.release_pending = 1'b1;
                        end else if (link.release_pending) begin
                           r.touch_event = EV_RELEASED;
                           r.x_pos = link.down_x;
                           r.y_pos = link.down_y;
                           link.release_pending = 1'b0;
                        end
                     end
                  end else begin
                     link.attempts = link.attempts + 3'd1;
                     if (link.attempts >= attempts_cfg) begin
                        r.done_res = 1'b1;
                        link.phase = PH_IDLE;
                     end else begin
                        begin_attempt();
                     end
                  end
               end
            end
         endcase
      end
      case (link.phase)
         PH_LOW: begin
            r.line_drive_enable = 1'b1;
            r.line_level = 1'b0;
         end
         PH_SEND, PH_TAIL: begin
            r.line_drive_enable = 1'b1;
            r.line_level = link.tx_shift[15];
         end
         PH_WAIT, PH_RECV: begin
            r.line_drive_enable = 1'b0;
            r.line_level = 1'b0;
         end
         default: begin
            r.line_drive_enable = 1'b1;
            r.line_level = 1'b1;
         end
      endcase
      r.busy_res = (link.phase != PH_IDLE);
      r.response_word = link.rx_shift;
      return r;
   endfunction

   function automatic void check_report_fields(input rsp_item_type got, input rsp_item_type want);
      if (got.line_drive_enable !== want.line_drive_enable) begin
         $error("line_drive_enable: expected %0h, got %0h",
                want.line_drive_enable, got.line_drive_enable);
         errors++;
      end
      if (got.line_level !== want.line_level) begin
         $error("line_level: expected %0h, got %0h", want.line_level, got.line_level);
         errors++;
      end
      if (got.busy_res !== want.busy_res) begin
         $error("busy_res: expected %0h, got %0h", want.busy_res, got.busy_res);
         errors++;
      end
      if (got.done_res !== want.done_res) begin
         $error("done_res: expected %0h, got %0h", want.done_res, got.done_res);
         errors++;
      end
      if (got.ok !== want.ok) begin
         $error("ok: expected %0h, got %0h", want.ok, got.ok);
         errors++;
      end
      if (got.response_word !== want.response_word) begin
         $error("response_word: expected %08h, got %08h",
                want.response_word, got.response_word);
         errors++;
      end
      if (got.x_pos !== want.x_pos) begin
         $error("x_pos: expected %03h, got %03h", want.x_pos, got.x_pos);
         errors++;
      end
      if (got.y_pos !== want.y_pos) begin
         $error("y_pos: expected %03h, got %03h", want.y_pos, got.y_pos);
         errors++;
      end
      if (got.touching !== want.touching) begin
         $error("touching: expected %0h, got %0h", want.touching, got.touching);
         errors++;
      end
      if (got.touch_event !== want.touch_event) begin
         $error("touch_event: expected %0h, got %0h", want.touch_event, got.touch_event);
         errors++;
      end
   endfunction

   // Result side: random stall, and every accepted word checked in order.
   always @(posedge clock) begin
      rsp_item_type got;
      rsp_item_type want;
      if (reset == 1'b0 && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         got = {rsp_line_drive_enable, rsp_line_level, rsp_busy_res, rsp_done_res, rsp_ok,
                rsp_response_word, rsp_x_pos, rsp_y_pos, rsp_touching, rsp_touch_event};
         if (link_reports_due.size() == 0) begin
            $error("Result word arrived with no request outstanding");
            errors++;
         end else begin
            want = link_reports_due.pop_front();
            check_report_fields(got, want);
            if (want.done_res) sessions_done++;
            if (want.ok) sessions_good++;
            if (want.touch_event == EV_DOWN) downs_seen++;
            if (want.touch_event == EV_RELEASED) releases_seen++;
         end
      end
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Offers one request word, waits for it to be taken and records what it should show.
   task automatic send_word(input req_item_type w, input logic typed, input rsp_item_type shown);
      rsp_item_type want;
      case ((words_sent / 90) % 4)
         0: begin
            sender_idle_pct = 0;
            stall_pct = 0;
         end
         1: begin
            sender_idle_pct = 57;
            stall_pct = 0;
         end
         2: begin
            sender_idle_pct = 0;
            stall_pct = 57;
         end
         default: begin
            sender_idle_pct = 37;
            stall_pct = 37;
         end
      endcase
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= w.mode;
      req_brightness <= w.brightness;
      req_line_sample <= w.line_sample;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      want = step_link_session(w);
      link_reports_due.push_back(typed ? shown : want);
      words_sent++;
   endtask

   // A panel reply with a random position, a matching check byte, and sometimes one bit flipped.
   task automatic plan_reply(input int bad_pct);
      logic [11:0] x;
      logic [11:0] y;
      logic [23:0] top;
      int          pick;
      x = 12'($urandom);
      y = 12'($urandom);
      pick = $urandom_range(99);
      if (pick < 15) begin
         x = NO_TOUCH_POS;
      end else if (pick < 30) begin
         y = NO_TOUCH_POS;
      end else if (pick < 35) begin
         x = NO_TOUCH_POS;
         y = NO_TOUCH_POS;
      end else if (pick < 40) begin
         x = '0;
         y = '0;
      end else if (pick < 45) begin
         x = NO_TOUCH_POS - 12'd1;
         y = NO_TOUCH_POS - 12'd1;
      end
      top = {x[11:8], y[11:8], x[7:0], y[7:0]};
      reply_bits = {top, link_crc({top, 8'd0}, 24)};
      if ($urandom_range(99) < bad_pct) begin
         reply_bits[$urandom_range(31)] ^= 1'b1;
      end
   endtask

   // Runs whole sessions until the word count is reached and the link is idle again.
   task automatic run_sessions(input int words, input int bad_pct);
      req_item_type w;
      int           counted;
      logic         effective;
      counted = 0;
      while (counted < words || link.phase != PH_IDLE) begin
         w.mode = MODE_TICK;
         w.brightness = 8'($urandom);
         w.line_sample = 1'($urandom);
         if (link.phase == PH_IDLE) begin
            case ($urandom_range(99)) inside
               [0:7]:   w.mode = MODE_TICK;
               [8:11]:  w.mode = MODE_NONE;
               [12:74]: w.mode = MODE_TOUCH;
               default: w.mode = MODE_LIGHT;
            endcase
         end else if ($urandom_range(99) < 6) begin
            case ($urandom_range(2))
               0:       w.mode = MODE_TOUCH;
               1:       w.mode = MODE_LIGHT;
               default: w.mode = MODE_NONE;
            endcase
         end else if (link.phase == PH_RECV) begin
            if (link.bits == 0) plan_reply(bad_pct);
            w.line_sample = reply_bits[31 - int'(link.bits)];
         end
         effective = (link.phase == PH_IDLE) ? (w.mode == MODE_TOUCH || w.mode == MODE_LIGHT)
                                             : (w.mode == MODE_TICK);
         send_word(w, 1'b0, '0);
         if (effective) counted++;
      end
   endtask

   // Stops offering words and waits until every outstanding word has come back.
   task automatic settle_link();
      req_valid <= 1'b0;
      while (link_reports_due.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_reg(input logic index, input logic [7:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      if (index == CSR_HOLD_TICKS) begin
         hold_cfg = data;
      end else begin
         attempts_cfg = data[2:0];
      end
   endtask

   initial begin
      int row;
      int setting;
      hold_cfg = HOLD_TICKS_RESET;
      attempts_cfg = MAX_ATTEMPTS_RESET;
      link = '0;
      link.phase = PH_IDLE;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (row = 0; row < DIRECTED_ROWS; row++) begin
         send_word(DIRECTED[row].stim, DIRECTED[row].typed, DIRECTED[row].shown);
      end

      // The first setting keeps the reset values and finishes the session opened above.
      for (setting = 0; setting < SETTINGS_COUNT; setting++) begin
         if (setting > 0) begin
            settle_link();
            case (setting)
               1: begin
                  write_reg(CSR_HOLD_TICKS, 8'h00);
                  write_reg(CSR_MAX_ATTEMPTS, 8'hF8);
               end
               2: begin
                  write_reg(CSR_HOLD_TICKS, 8'hFF);
                  write_reg(CSR_MAX_ATTEMPTS, 8'h01);
               end
               3: begin
                  write_reg(CSR_HOLD_TICKS, 8'h01);
                  write_reg(CSR_MAX_ATTEMPTS, 8'h07);
               end
               default: begin
                  write_reg(CSR_MAX_ATTEMPTS, 8'($urandom));
                  write_reg(CSR_HOLD_TICKS, 8'($urandom_range(12, 2)));
               end
            endcase
            csr_valid <= 1'b0;
         end
         run_sessions(SETTING_WORDS[setting], SETTING_BAD_PCT[setting]);
      end
      settle_link();

      $display("Sent %0d request words over %0d register settings with gaps and stalls.",
               words_sent, SETTINGS_COUNT);
      $display("Sessions ended: %0d, good replies: %0d, touch downs: %0d, releases: %0d.",
               sessions_done, sessions_good, downs_seen, releases_seen);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Run did not finish in the allowed time.");
      $display("DONE: errors detected");
      $finish;
   end

endmodule
